### rtl/negative_film_inversion_core_macros.svh
// assertion helpers included by the core module
`ifndef NEGATIVE_FILM_INVERSION_CORE_MACROS_SVH
`define NEGATIVE_FILM_INVERSION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NFI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NFI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nfi_pkg.sv
package nfi_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 23;
    localparam int LOG_W    = 21;
    localparam int RESULT_W = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [RATIO_W-1:0] RATIO_MAX = 23'h7FFFFF;

    // stage counts of the datapath units
    localparam int DIV_LAT  = 24;
    localparam int LOG_LAT  = 17;
    localparam int EXP_LAT  = 19;
    localparam int CORE_LAT = DIV_LAT + LOG_LAT + EXP_LAT;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_RED     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_GREEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BLUE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_OFFSET = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA_GREEN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA_BLUE   = 3'd6;

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic [RATIO_W-1:0]         ratio_t;
    typedef logic signed [LOG_W-1:0]    log_t;
    typedef logic signed [RESULT_W-1:0] result_t;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
    } pix_t;

    // truncated integer square root, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bval;
        rem  = v;
        res  = '0;
        bval = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bval)
            begin
                rem = rem - (res + bval);
                res = (res >> 1) + bval;
            end
            else
            begin
                res = res >> 1;
            end
            bval = bval >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30 along the square root chain
    function automatic logic [30:0] root_const(input int k);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int j = 1; j <= k; j++)
        begin
            c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage

### rtl/nfi_in_if.sv
interface nfi_in_if;
    logic            valid;
    logic            ready;
    nfi_pkg::sample_t red_in;
    nfi_pkg::sample_t green_in;
    nfi_pkg::sample_t blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

### rtl/nfi_out_if.sv
interface nfi_out_if;
    logic              valid;
    logic              ready;
    nfi_pkg::result_t  red_out;
    nfi_pkg::result_t  green_out;
    nfi_pkg::result_t  blue_out;
    logic              overflow;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output overflow, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input overflow, output ready);
endinterface

### rtl/negative_film_inversion_core.sv
// channel   dir  payload                                   request
// pix_in    in   red_in, green_in, blue_in (u16 each)      one pixel
// pix_out   out  red_out, green_out, blue_out (s24), ovf   one inverted pixel
// cfg       in   cfg_write, cfg_index, cfg_data            one register write
//
// one pixel per cycle sustained while the output is not held
// pipeline depth is set by the bit-per-stage dividers, the squaring log2 chain and
// the square root product chain, each one multiply or compare per stage
// rst_n clears the registers and all valid bits, payload is not reset
// one clock enable stalls every stage together when the output is held
module negative_film_inversion_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [nfi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data,
    nfi_in_if.sink                            pix_in,
    nfi_out_if.source                         pix_out
);
    import nfi_pkg::*;

    `include "negative_film_inversion_core_macros.svh"

    localparam int RED_DLY = LOG_LAT + EXP_LAT;

    // configuration registers
    logic    enable_reg;
    sample_t base_red_reg;
    sample_t base_green_reg;
    sample_t base_blue_reg;
    sample_t light_reg;
    sample_t gamma_green_reg;
    sample_t gamma_blue_reg;

    // pipeline control
    logic                ce;
    logic [CORE_LAT-1:0] vld_reg;
    logic                out_valid_reg;

    // sideband delay lines
    pix_t   pass_reg    [0:CORE_LAT-1];
    ratio_t red_dly_reg [0:RED_DLY-1];
    logic   dovf_reg    [0:RED_DLY-1];

    // datapath taps
    ratio_t ratio_r, ratio_g, ratio_b;
    logic   ovf_r, ovf_g, ovf_b;
    log_t   log_g, log_b;
    logic   zero_g, zero_b;
    ratio_t pow_g, pow_b;
    logic   povf_g, povf_b;

    // output register
    result_t red_out_reg, green_out_reg, blue_out_reg;
    logic    ovf_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            base_red_reg    <= '0;
            base_green_reg  <= '0;
            base_blue_reg   <= '0;
            light_reg       <= '0;
            gamma_green_reg <= '0;
            gamma_blue_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ENABLE:       enable_reg      <= cfg_data[0];
                CFG_BASE_RED:     base_red_reg    <= cfg_data;
                CFG_BASE_GREEN:   base_green_reg  <= cfg_data;
                CFG_BASE_BLUE:    base_blue_reg   <= cfg_data;
                CFG_LIGHT_OFFSET: light_reg       <= cfg_data;
                CFG_GAMMA_GREEN:  gamma_green_reg <= cfg_data;
                CFG_GAMMA_BLUE:   gamma_blue_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // whole pipe moves unless a finished pixel is held at the output
    assign ce           = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg       <= {vld_reg[CORE_LAT-2:0], pix_in.valid};
            out_valid_reg <= vld_reg[CORE_LAT-1];
        end
    end

    // raw samples kept for passthrough
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pass_reg[0] <= '{red: pix_in.red_in, green: pix_in.green_in,
                             blue: pix_in.blue_in};
            for (int i = 1; i < CORE_LAT; i++)
            begin
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    // ratio = base / sample per channel
    nfi_div u_div_r (.clk(clk), .ce(ce), .base(base_red_reg), .sample(pix_in.red_in),
                     .ratio(ratio_r), .ovf(ovf_r));
    nfi_div u_div_g (.clk(clk), .ce(ce), .base(base_green_reg), .sample(pix_in.green_in),
                     .ratio(ratio_g), .ovf(ovf_g));
    nfi_div u_div_b (.clk(clk), .ce(ce), .base(base_blue_reg), .sample(pix_in.blue_in),
                     .ratio(ratio_b), .ovf(ovf_b));

    // red skips the power, so it waits for green and blue here
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            red_dly_reg[0] <= ratio_r;
            dovf_reg[0]    <= ovf_r || ovf_g || ovf_b;
            for (int i = 1; i < RED_DLY; i++)
            begin
                red_dly_reg[i] <= red_dly_reg[i-1];
                dovf_reg[i]    <= dovf_reg[i-1];
            end
        end
    end

    // green and blue: exp2(gamma * log2(ratio))
    nfi_log2 u_log_g (.clk(clk), .ce(ce), .ratio(ratio_g), .log_val(log_g), .zero(zero_g));
    nfi_log2 u_log_b (.clk(clk), .ce(ce), .ratio(ratio_b), .log_val(log_b), .zero(zero_b));

    nfi_exp2 u_exp_g (.clk(clk), .ce(ce), .log_val(log_g), .zero_in(zero_g),
                      .gamma(gamma_green_reg), .power(pow_g), .ovf(povf_g));
    nfi_exp2 u_exp_b (.clk(clk), .ce(ce), .log_val(log_b), .zero_in(zero_b),
                      .gamma(gamma_blue_reg), .power(pow_b), .ovf(povf_b));

    // light offset subtract, never leaves the 24 bit range
    logic [24:0] sub_r, sub_g, sub_b;
    assign sub_r = {2'b0, red_dly_reg[RED_DLY-1]} - {9'b0, light_reg};
    assign sub_g = {2'b0, pow_g} - {9'b0, light_reg};
    assign sub_b = {2'b0, pow_b} - {9'b0, light_reg};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (enable_reg)
            begin
                red_out_reg   <= sub_r[23:0];
                green_out_reg <= sub_g[23:0];
                blue_out_reg  <= sub_b[23:0];
                ovf_out_reg   <= dovf_reg[RED_DLY-1] || povf_g || povf_b;
            end
            else
            begin
                red_out_reg   <= {8'b0, pass_reg[CORE_LAT-1].red};
                green_out_reg <= {8'b0, pass_reg[CORE_LAT-1].green};
                blue_out_reg  <= {8'b0, pass_reg[CORE_LAT-1].blue};
                ovf_out_reg   <= 1'b0;
            end
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = red_out_reg;
    assign pix_out.green_out = green_out_reg;
    assign pix_out.blue_out  = blue_out_reg;
    assign pix_out.overflow  = ovf_out_reg;

    // an accepted pixel enters the first stage
    `NFI_ASSERT_NEXT(a_accept_enters, pix_in.valid && pix_in.ready, vld_reg[0], "accepted pixel lost")
    // a stall freezes every valid bit
    `NFI_ASSERT_NEXT(a_stall_holds, !ce, $stable(vld_reg) && out_valid_reg, "stall moved the pipe")
    // a taken result with nothing behind it leaves the output empty
    `NFI_ASSERT_NEXT(a_drain, pix_out.valid && pix_out.ready && !vld_reg[CORE_LAT-1], !pix_out.valid, "result repeated")
endmodule

### rtl/nfi_div.sv
module nfi_div (
    input  logic             clk,
    input  logic             ce,
    input  nfi_pkg::sample_t base,
    input  nfi_pkg::sample_t sample,
    output nfi_pkg::ratio_t  ratio,
    output logic             ovf
);
    import nfi_pkg::*;

    logic [31:0]         rem_reg [0:RATIO_W-1];
    logic [SAMPLE_W-1:0] dvs_reg [0:RATIO_W-1];
    ratio_t              quo_reg [0:RATIO_W];
    logic                sat_reg [0:RATIO_W];

    // quotient reaches 2^23 exactly when base >= sample * 128
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= {base, 16'h0000};
            dvs_reg[0] <= sample;
            quo_reg[0] <= '0;
            sat_reg[0] <= (sample == '0) || ({7'b0, base} >= {sample, 7'b0});
        end
    end

    for (genvar k = 0; k < RATIO_W; k++)
    begin : g_bit
        localparam int SH = RATIO_W - 1 - k;
        localparam ratio_t MASK = ratio_t'(1) << SH;
        logic [38:0] dd;
        logic [38:0] rr;
        logic [38:0] diff;
        logic        ge;

        assign dd   = {23'b0, dvs_reg[k]} << SH;
        assign rr   = {7'b0, rem_reg[k]};
        assign ge   = (rr >= dd);
        assign diff = rr - dd;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                quo_reg[k+1] <= ge ? (quo_reg[k] | MASK) : quo_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end

        if (k < RATIO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k+1] <= ge ? diff[31:0] : rem_reg[k];
                    dvs_reg[k+1] <= dvs_reg[k];
                end
            end
        end
    end

    assign ratio = sat_reg[RATIO_W] ? RATIO_MAX : quo_reg[RATIO_W];
    assign ovf   = sat_reg[RATIO_W];
endmodule

### rtl/nfi_log2.sv
module nfi_log2 (
    input  logic            clk,
    input  logic            ce,
    input  nfi_pkg::ratio_t ratio,
    output nfi_pkg::log_t   log_val,
    output logic            zero
);
    import nfi_pkg::*;

    localparam int STEPS = 16;

    logic [4:0]  lead;
    logic [30:0] norm;

    logic [30:0] x_reg    [0:STEPS-1];
    logic [4:0]  p_reg    [0:STEPS];
    logic [15:0] frac_reg [0:STEPS];
    logic        zero_reg [0:STEPS];

    // leading one position
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < RATIO_W; i++)
        begin
            if (ratio[i])
            begin
                lead = 5'(i);
            end
        end
    end

    assign norm = {8'b0, ratio} << (5'd30 - lead);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0]    <= norm;
            p_reg[0]    <= lead;
            frac_reg[0] <= '0;
            zero_reg[0] <= (ratio == '0);
        end
    end

    // one fraction bit per squaring
    for (genvar j = 0; j < STEPS; j++)
    begin : g_sq
        localparam logic [15:0] MASK = 16'(1) << (STEPS - 1 - j);
        logic [61:0] sq;
        logic [31:0] s;

        assign sq = x_reg[j] * x_reg[j];
        assign s  = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                p_reg[j+1]    <= p_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                frac_reg[j+1] <= s[31] ? (frac_reg[j] | MASK) : frac_reg[j];
            end
        end

        if (j < STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    x_reg[j+1] <= s[31] ? s[31:1] : s[30:0];
                end
            end
        end
    end

    assign log_val = {5'(p_reg[STEPS] - 5'd16), frac_reg[STEPS]};
    assign zero    = zero_reg[STEPS];
endmodule

### rtl/nfi_exp2.sv
module nfi_exp2 (
    input  logic            clk,
    input  logic            ce,
    input  nfi_pkg::log_t   log_val,
    input  logic            zero_in,
    input  logic [15:0]     gamma,
    output nfi_pkg::ratio_t power,
    output logic            ovf
);
    import nfi_pkg::*;

    localparam int STEPS = 16;

    localparam logic [1:0] PW_NORMAL = 2'd0;
    localparam logic [1:0] PW_ONE    = 2'd1;
    localparam logic [1:0] PW_ZERO   = 2'd2;
    localparam logic [1:0] PW_SAT    = 2'd3;

    localparam logic [30:0] ONE30 = 31'h4000_0000;

    logic signed [37:0] prod_reg;
    logic               zero_a_reg;
    logic               gz_a_reg;

    logic signed [9:0]  n_val;
    logic [4:0]         sh_val;
    logic [1:0]         code_val;

    logic [30:0] cp_reg   [0:STEPS];
    logic [15:0] f_reg    [0:STEPS-1];
    logic [4:0]  sh_reg   [0:STEPS];
    logic [1:0]  code_reg [0:STEPS];

    ratio_t power_reg;
    logic   ovf_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prod_reg   <= log_val * $signed({1'b0, gamma});
            zero_a_reg <= zero_in;
            gz_a_reg   <= (gamma == '0);
        end
    end

    // exponent = prod >>> 12, integer part n, fraction f
    assign n_val  = prod_reg[37:28];
    assign sh_val = 5'(10'sd14 - n_val);

    always_comb
    begin
        priority if (gz_a_reg)
            code_val = PW_ONE;
        else if (zero_a_reg)
            code_val = PW_ZERO;
        else if (n_val >= 10'sd7)
            code_val = PW_SAT;
        else if (n_val < -10'sd16)
            code_val = PW_ZERO;
        else
            code_val = PW_NORMAL;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cp_reg[0]   <= ONE30;
            f_reg[0]    <= prod_reg[27:12];
            sh_reg[0]   <= sh_val;
            code_reg[0] <= code_val;
        end
    end

    // multiply in 2^(2^-k) for each set fraction bit
    for (genvar k = 0; k < STEPS; k++)
    begin : g_mul
        localparam logic [30:0] C = root_const(k + 1);
        logic [61:0] mp;

        assign mp = cp_reg[k] * C;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                cp_reg[k+1]   <= f_reg[k][STEPS-1-k] ? mp[60:30] : cp_reg[k];
                sh_reg[k+1]   <= sh_reg[k];
                code_reg[k+1] <= code_reg[k];
            end
        end

        if (k < STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    f_reg[k+1] <= f_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            unique case (code_reg[STEPS])
                PW_ONE:    power_reg <= 23'h010000;
                PW_ZERO:   power_reg <= '0;
                PW_SAT:    power_reg <= RATIO_MAX;
                PW_NORMAL: power_reg <= 23'(cp_reg[STEPS] >> sh_reg[STEPS]);
                default:   power_reg <= '0;
            endcase
            ovf_reg <= (code_reg[STEPS] == PW_SAT);
        end
    end

    assign power = power_reg;
    assign ovf   = ovf_reg;
endmodule

### tb/negative_film_inversion_core_tb.sv
`default_nettype none

module negative_film_inversion_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = CORE_LAT + 10;
    localparam logic [23:0] QMAX24 = 24'h7FFFFF;

    typedef struct packed {
        result_t red;
        result_t green;
        result_t blue;
        logic    ovf;
    } inv_pix_t;

    // one queued outcome: the predicted pixel, plus a hand-written one for some table rows
    typedef struct {
        inv_pix_t calc;
        bit       has_typed;
        inv_pix_t typed;
    } outcome_t;

    // one directed stimulus row
    typedef struct {
        int       preset;
        sample_t  r;
        sample_t  g;
        sample_t  b;
        bit       has_typed;
        inv_pix_t typed;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    nfi_in_if  pix_in ();
    nfi_out_if pix_out ();

    negative_film_inversion_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in.sink),
        .pix_out   (pix_out.source)
    );

    // shadow copy of the register file
    logic        sh_enable;
    logic [15:0] sh_base_r;
    logic [15:0] sh_base_g;
    logic [15:0] sh_base_b;
    logic [15:0] sh_light;
    logic [15:0] sh_gamma_g;
    logic [15:0] sh_gamma_b;

    // 2^(2^-k) in Q1.30, filled at time zero
    longint unsigned root_chain [1:16];

    outcome_t    pending_q [$];
    stim_row_t   stim_rows [$];

    int err_count;
    int n_sent;
    int n_recv;
    int n_ovf;
    int n_configs;
    int src_idle;
    int snk_idle;
    int quiet_cycles;

    // payload side info travelling with the current request
    bit       cur_has_typed;
    inv_pix_t cur_typed;

    // ---------------------------------------------------------------- clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // ------------------------------------------------------------ predictor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned t;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if (t * t <= v)
                res = t;
        end
        return res;
    endfunction

    // base/sample in Q7.16, saturating, zero sample saturates
    function automatic logic [22:0] film_ratio(input logic [15:0] base, input logic [15:0] smp,
                                              inout logic ovf);
        longint unsigned q;
        if (smp == 0)
        begin
            ovf = 1'b1;
            return RATIO_MAX;
        end
        q = (longint'(base) << 16) / longint'(smp);
        if (q > 64'd8388607)
        begin
            ovf = 1'b1;
            return RATIO_MAX;
        end
        return q[22:0];
    endfunction

    // log2 in signed Q.16 by repeated squaring of the mantissa
    function automatic longint fix_log2(input logic [22:0] r);
        int p;
        longint unsigned x;
        longint frac;
        p = 22;
        frac = 0;
        while (p > 0 && r[p] == 1'b0)
            p--;
        x = longint'(r) << (30 - p);
        for (int i = 1; i <= 16; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                frac = frac | (64'sd1 << (16 - i));
            end
        end
        return longint'(p - 16) * 65536 + frac;
    endfunction

    function automatic logic [31:0] gamma_power(input logic [22:0] ratio, input logic [15:0] gam,
                                               inout logic ovf);
        longint e;
        longint n;
        longint unsigned f;
        longint unsigned prod;
        longint sh;
        if (gam == 0)
            return 32'd65536;
        if (ratio == 0)
            return 32'd0;
        e = (fix_log2(ratio) * longint'(gam)) >>> 12;
        n = e >>> 16;
        f = e - n * 65536;
        if (n >= 7)
        begin
            ovf = 1'b1;
            return 32'(QMAX24);
        end
        prod = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            if (f[16-k])
                prod = (prod * root_chain[k]) >> 30;
        end
        sh = 14 - n;
        if (sh >= 63)
            return 32'd0;
        return 32'(prod >> sh);
    endfunction

    function automatic inv_pix_t invert_pixel(input sample_t r, input sample_t g, input sample_t b);
        inv_pix_t o;
        logic ovf;
        logic [22:0] rr;
        logic [22:0] rg;
        logic [22:0] rb;
        logic [31:0] pg;
        logic [31:0] pb;
        ovf = 1'b0;
        if (!sh_enable)
        begin
            o.red   = result_t'({8'd0, r});
            o.green = result_t'({8'd0, g});
            o.blue  = result_t'({8'd0, b});
            o.ovf   = 1'b0;
            return o;
        end
        rr = film_ratio(sh_base_r, r, ovf);
        rg = film_ratio(sh_base_g, g, ovf);
        pg = gamma_power(rg, sh_gamma_g, ovf);
        rb = film_ratio(sh_base_b, b, ovf);
        pb = gamma_power(rb, sh_gamma_b, ovf);
        o.red   = result_t'(longint'(rr) - longint'(sh_light));
        o.green = result_t'(longint'(pg) - longint'(sh_light));
        o.blue  = result_t'(longint'(pb) - longint'(sh_light));
        o.ovf   = ovf;
        return o;
    endfunction

    // ----------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH %s: got %06h want %06h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        outcome_t oc;
        inv_pix_t want;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // accepted pixel request: predict now, config is stable while traffic flows
            if (pix_in.valid && pix_in.ready)
            begin
                oc.calc      = invert_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in);
                oc.has_typed = cur_has_typed;
                oc.typed     = cur_typed;
                pending_q.push_back(oc);
                n_sent++;
                moved = 1'b1;
            end
            if (pix_out.valid && pix_out.ready)
            begin
                moved = 1'b1;
                n_recv++;
                if (pending_q.size() == 0)
                begin
                    report_mismatch("unexpected result", pix_out.red_out, '0);
                end
                else
                begin
                    oc = pending_q.pop_front();
                    want = oc.has_typed ? oc.typed : oc.calc;
                    // a hand-written row must also agree with the predictor
                    if (oc.has_typed && oc.typed != oc.calc)
                        report_mismatch("table vs predictor", oc.calc.red, oc.typed.red);
                    if (pix_out.red_out !== want.red)
                        report_mismatch("red_out", pix_out.red_out, want.red);
                    if (pix_out.green_out !== want.green)
                        report_mismatch("green_out", pix_out.green_out, want.green);
                    if (pix_out.blue_out !== want.blue)
                        report_mismatch("blue_out", pix_out.blue_out, want.blue);
                    if (pix_out.overflow !== want.ovf)
                        report_mismatch("overflow", {23'b0, pix_out.overflow},
                                        {23'b0, want.ovf});
                    if (want.ovf)
                        n_ovf++;
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no request moving either way
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ----------------------------------------------------------- receiver
    always @(negedge clk)
    begin
        pix_out.ready <= ($urandom_range(99) >= snk_idle);
    end

    // ------------------------------------------------------------ driving
    task automatic send_pixel(input sample_t r, input sample_t g, input sample_t b,
                              input bit has_typed, input inv_pix_t typed);
        bit done;
        while ($urandom_range(99) < src_idle)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= r;
        pix_in.green_in <= g;
        pix_in.blue_in  <= b;
        cur_has_typed   <= has_typed;
        cur_typed       <= typed;
        done = 1'b0;
        while (!done)
        begin
            @(posedge clk);
            done = pix_in.valid && pix_in.ready;
            @(negedge clk);
        end
    endtask

    // sender holds off until everything in flight has come out, then lets the pipe settle
    task automatic drain_block();
        pix_in.valid <= 1'b0;
        @(negedge clk);
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_all_regs(input logic en, input logic [15:0] br, input logic [15:0] bg,
                                  input logic [15:0] bb, input logic [15:0] lt,
                                  input logic [15:0] gg, input logic [15:0] gb);
        logic [15:0] vals [7];
        logic [CFG_INDEX_W-1:0] idx [7];
        vals = '{16'(en), br, bg, bb, lt, gg, gb};
        idx  = '{CFG_ENABLE, CFG_BASE_RED, CFG_BASE_GREEN, CFG_BASE_BLUE,
                 CFG_LIGHT_OFFSET, CFG_GAMMA_GREEN, CFG_GAMMA_BLUE};
        for (int i = 0; i < 7; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_write  <= 1'b0;
        sh_enable  = en;
        sh_base_r  = br;
        sh_base_g  = bg;
        sh_base_b  = bb;
        sh_light   = lt;
        sh_gamma_g = gg;
        sh_gamma_b = gb;
        n_configs++;
        @(negedge clk);
    endtask

    task automatic apply_preset(input int k);
        case (k)
            1: write_all_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
            2: write_all_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h1000, 16'h1000);
            3: write_all_regs(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h0800, 16'h2000);
            4: write_all_regs(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            5: write_all_regs(1'b1, 16'h3000, 16'h5000, 16'h7000, 16'h0800, 16'h1CCD, 16'h0400);
            default: write_all_regs(1'b0, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555,
                                    16'h6666);
        endcase
    endtask

    function automatic logic [15:0] pick_reg16(input int max_typ);
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(max_typ));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            3: return 16'($urandom_range(65535, 49152));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(input int preset, input sample_t r, input sample_t g, input sample_t b,
                           input bit has, input logic [23:0] er, input logic [23:0] eg,
                           input logic [23:0] eb, input logic eo);
        stim_row_t row;
        row.preset    = preset;
        row.r         = r;
        row.g         = g;
        row.b         = b;
        row.has_typed = has;
        row.typed     = '{er, eg, eb, eo};
        stim_rows.push_back(row);
    endtask

    // ---------------------------------------------------------- main flow
    initial
    begin
        int cur_preset;
        stim_row_t row;
        inv_pix_t none;
        none = '0;
        err_count = 0;
        n_sent = 0;
        n_recv = 0;
        n_ovf = 0;
        n_configs = 0;
        quiet_cycles = 0;
        src_idle = 23;
        snk_idle = 66;
        cur_has_typed = 1'b0;
        cur_typed = '0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_out.ready = 1'b0;
        // registers come out of reset all zero
        sh_enable = 1'b0;
        sh_base_r = '0;
        sh_base_g = '0;
        sh_base_b = '0;
        sh_light = '0;
        sh_gamma_g = '0;
        sh_gamma_b = '0;

        begin
            longint unsigned c;
            c = 64'd2 << 30;
            for (int k = 1; k <= 16; k++)
            begin
                c = int_sqrt(c << 30);
                root_chain[k] = c;
            end
        end

        // passthrough right after reset
        add_row(0, 16'h0000, 16'h0000, 16'h0000, 1, 24'h000000, 24'h000000, 24'h000000, 0);
        add_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 0);
        add_row(0, 16'h1234, 16'h8000, 16'h0001, 1, 24'h001234, 24'h008000, 24'h000001, 0);
        // zero gamma gives unity power, zero sample saturates the ratio
        add_row(1, 16'h0000, 16'h0000, 16'h0000, 1, QMAX24, 24'h010000, 24'h010000, 1);
        add_row(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 24'h010000, 24'h010000, 24'h010000, 0);
        add_row(1, 16'h0001, 16'h0001, 16'h0001, 1, QMAX24, 24'h010000, 24'h010000, 1);
        // unity gamma, unity ratio; a saturated ratio leaves the power just under the limit
        add_row(2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 24'h010000, 24'h010000, 24'h010000, 0);
        add_row(2, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_row(2, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
        add_row(2, 16'h0100, 16'h0900, 16'h2000, 0, 0, 0, 0, 0);
        // zero base: zero ratio, power zero, result is minus the light offset
        add_row(3, 16'h5555, 16'h5555, 16'h5555, 1, 24'hFFEDCC, 24'hFFEDCC, 24'hFFEDCC, 0);
        add_row(3, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        // largest gamma and light offset
        add_row(4, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
        add_row(4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0);
        add_row(4, 16'h0100, 16'h0100, 16'h0100, 0, 0, 0, 0, 0);
        add_row(4, 16'h4000, 16'h6000, 16'h7FFF, 0, 0, 0, 0, 0);
        // typical film settings
        add_row(5, 16'h4000, 16'h6000, 16'h9000, 0, 0, 0, 0, 0);
        add_row(5, 16'h3000, 16'h5000, 16'h7000, 0, 0, 0, 0, 0);
        add_row(5, 16'hC000, 16'hE000, 16'hFFFF, 0, 0, 0, 0, 0);
        add_row(5, 16'h0010, 16'h0020, 16'h0040, 0, 0, 0, 0, 0);
        // disabled again with nonzero registers
        add_row(6, 16'hABCD, 16'h0000, 16'hFFFF, 1, 24'h00ABCD, 24'h000000, 24'h00FFFF, 0);
        add_row(6, 16'h0001, 16'h7FFF, 16'h8000, 1, 24'h000001, 24'h007FFF, 24'h008000, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        cur_preset = 0;
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.preset != cur_preset)
            begin
                drain_block();
                apply_preset(row.preset);
                cur_preset = row.preset;
            end
            send_pixel(row.r, row.g, row.b, row.has_typed, row.typed);
        end

        // random part: three idling patterns, several register settings each
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin src_idle = 23; snk_idle = 66; end
                1: begin src_idle = 66; snk_idle = 23; end
                default: begin src_idle = 0; snk_idle = 0; end
            endcase
            for (int s = 0; s < 5; s++)
            begin
                drain_block();
                write_all_regs(($urandom_range(7) != 0), pick_reg16(16'hFFFF),
                               pick_reg16(16'hFFFF), pick_reg16(16'hFFFF),
                               pick_reg16(16'h2000), pick_reg16(16'h4000),
                               pick_reg16(16'h4000));
                for (int n = 0; n < 115; n++)
                begin
                    // short bursts with no source idling
                    if (n % 40 < 10 && mode != 2)
                    begin
                        int saved;
                        saved = src_idle;
                        src_idle = 0;
                        send_pixel(pick_sample(), pick_sample(), pick_sample(), 0, none);
                        src_idle = saved;
                    end
                    else
                    begin
                        send_pixel(pick_sample(), pick_sample(), pick_sample(), 0, none);
                    end
                end
            end
        end

        drain_block();

        $display("covered %0d pixels over %0d register settings, %0d with overflow",
                 n_sent, n_configs, n_ovf);
        $display("passthrough, zero base, zero sample, saturation and three idle patterns");
        if (err_count == 0 && pending_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", err_count, pending_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
